// File: src/lrcs_pkg.sv
// shared types and constants for the least-run-count scheduler
package lrcs_pkg;

    localparam int MASK_W     = 16;
    localparam int OUT_TASK_W = 4;
    localparam int COUNT_W    = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PICK,
        ST_WRITE
    } t_state;

    // phase strobes from the sequencer to every cell
    typedef struct packed {
        logic pick;
        logic update;
    } t_cell_ctl;

    // left-to-right chain between neighboring cells
    typedef struct packed {
        logic hit;
        logic past;
    } t_chain_link;

endpackage

// File: src/lrcs_if.sv
// handshake channels for scheduling requests and decisions
interface lrcs_in_if;
    logic                          valid;
    logic                          ready;
    logic [lrcs_pkg::MASK_W-1:0]   runnable_mask;

    modport source (output valid, output runnable_mask, input ready);
    modport sink   (input valid, input runnable_mask, output ready);
endinterface

interface lrcs_out_if;
    logic                             valid;
    logic                             ready;
    logic                             found;
    logic [lrcs_pkg::OUT_TASK_W-1:0]  chosen_task;
    logic [lrcs_pkg::COUNT_W-1:0]     chosen_count;

    modport source (output valid, output found, output chosen_task, output chosen_count,
                    input ready);
    modport sink   (input valid, input found, input chosen_task, input chosen_count,
                    output ready);
endinterface

// File: src/lrcs_cell.sv
// one queue entry: task number, run count, select flag and shift logic
module lrcs_cell #(
    parameter int TASK_W    = 4,
    parameter int TASK_SPAN = 16,
    parameter int INDEX     = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lrcs_pkg::t_cell_ctl           i_ctl,
    input  logic [TASK_SPAN-1:0]          i_mask,
    input  lrcs_pkg::t_chain_link         i_link,
    output lrcs_pkg::t_chain_link         o_link,
    input  logic [TASK_W-1:0]             i_new_task,
    input  logic [lrcs_pkg::COUNT_W-1:0]  i_new_count,
    input  logic [TASK_W-1:0]             i_right_task,
    input  logic [lrcs_pkg::COUNT_W-1:0]  i_right_count,
    input  logic                          i_right_shift,
    output logic [TASK_W-1:0]             o_task,
    output logic [lrcs_pkg::COUNT_W-1:0]  o_count,
    output logic                          o_shift,
    output logic                          o_sel,
    output logic [TASK_W-1:0]             o_pick_task,
    output logic [lrcs_pkg::COUNT_W-1:0]  o_pick_count
);

    logic [TASK_W-1:0]            r_task;
    logic [lrcs_pkg::COUNT_W-1:0] r_count;
    logic                         r_sel;
    logic                         w_runnable;
    logic                         w_sel;

    assign w_runnable  = i_mask[r_task];
    assign w_sel       = w_runnable & ~i_link.hit;
    assign o_link.hit  = i_link.hit | w_runnable;
    assign o_link.past = i_link.past | r_sel;
    // entries behind the chosen one whose count is below the new count slide forward
    assign o_shift     = i_link.past & (r_count < i_new_count);

    assign o_task       = r_task;
    assign o_count      = r_count;
    assign o_sel        = r_sel;
    assign o_pick_task  = w_sel ? r_task : '0;
    assign o_pick_count = w_sel ? r_count : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_task  <= TASK_W'(INDEX);
            r_count <= '0;
            r_sel   <= 1'b0;
        end else begin
            if (i_ctl.pick) begin
                r_sel <= w_sel;
            end
            if (i_ctl.update) begin
                if ((r_sel | i_link.past) & i_right_shift) begin
                    r_task  <= i_right_task;
                    r_count <= i_right_count;
                end else if (r_sel | o_shift) begin
                    r_task  <= i_new_task;
                    r_count <= i_new_count;
                end
            end
        end
    end

endmodule

// File: src/least_run_count_scheduler_unit.sv
// Least-run-count scheduler: a row of TASKS cells holds the task queue in ascending run
// count order. Each request has a pick phase and then a write phase. In the pick phase, a
// priority chain through the cells finds the first runnable task in queue order and its
// count is incremented with saturation; in the write phase, every entry behind the chosen
// one with a count below the new count moves forward and the chosen task fills the gap; the
// decision is loaded into the output register. A new request is taken in the write phase
// while the output register is free or being emptied, so a stalled output holds the block.
// When no task is runnable the queue is left unchanged and found, task and count are zero.
module least_run_count_scheduler_unit #(
    parameter int TASKS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    lrcs_in_if.sink          i_in,
    lrcs_out_if.source       o_out
);

    localparam int TASK_W    = $clog2(TASKS);
    localparam int TASK_SPAN = 1 << TASK_W;

    lrcs_pkg::t_state                r_state;
    lrcs_pkg::t_state                n_state;
    logic [lrcs_pkg::MASK_W-1:0]     r_mask;
    logic                            r_found;
    logic [TASK_W-1:0]               r_task_c;
    logic [lrcs_pkg::COUNT_W-1:0]    r_count_c;
    logic                            r_out_valid;
    logic                            r_out_found;
    logic [lrcs_pkg::OUT_TASK_W-1:0] r_out_task;
    logic [lrcs_pkg::COUNT_W-1:0]    r_out_count;

    logic                            w_accept;
    logic                            w_can_out;
    logic                            w_finish;
    lrcs_pkg::t_cell_ctl             w_ctl;
    logic [TASK_SPAN-1:0]            w_mask_vec;
    lrcs_pkg::t_chain_link           w_link [TASKS+1];
    logic [TASK_W-1:0]               w_task [TASKS+1];
    logic [lrcs_pkg::COUNT_W-1:0]    w_count [TASKS+1];
    logic                            w_shift [TASKS+1];
    logic [TASKS-1:0]                w_sel;
    logic [TASK_W-1:0]               w_pick_task [TASKS];
    logic [lrcs_pkg::COUNT_W-1:0]    w_pick_count [TASKS];
    logic [TASK_W-1:0]               w_sel_task;
    logic [lrcs_pkg::COUNT_W-1:0]    w_sel_count;
    logic [lrcs_pkg::COUNT_W-1:0]    w_inc_count;
    logic [TASK_W+lrcs_pkg::OUT_TASK_W-1:0] w_task_ext;

    // tasks without a mask bit are never runnable
    for (genvar k = 0; k < TASK_SPAN; k++) begin : g_mask
        if (k < lrcs_pkg::MASK_W) begin : g_bit
            assign w_mask_vec[k] = r_mask[k];
        end else begin : g_none
            assign w_mask_vec[k] = 1'b0;
        end
    end

    assign w_link[0]      = '0;
    assign w_task[TASKS]  = '0;
    assign w_count[TASKS] = '0;
    assign w_shift[TASKS] = 1'b0;

    for (genvar k = 0; k < TASKS; k++) begin : g_cell
        lrcs_cell #(
            .TASK_W    (TASK_W),
            .TASK_SPAN (TASK_SPAN),
            .INDEX     (k)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_mask        (w_mask_vec),
            .i_link        (w_link[k]),
            .o_link        (w_link[k+1]),
            .i_new_task    (r_task_c),
            .i_new_count   (r_count_c),
            .i_right_task  (w_task[k+1]),
            .i_right_count (w_count[k+1]),
            .i_right_shift (w_shift[k+1]),
            .o_task        (w_task[k]),
            .o_count       (w_count[k]),
            .o_shift       (w_shift[k]),
            .o_sel         (w_sel[k]),
            .o_pick_task   (w_pick_task[k]),
            .o_pick_count  (w_pick_count[k])
        );
    end

    // one-hot select, so an or of the gated entries is the chosen one
    always_comb begin
        w_sel_task  = '0;
        w_sel_count = '0;
        for (int k = 0; k < TASKS; k++) begin
            w_sel_task  = w_sel_task | w_pick_task[k];
            w_sel_count = w_sel_count | w_pick_count[k];
        end
    end

    assign w_inc_count = (w_sel_count == lrcs_pkg::COUNT_MAX) ? w_sel_count
                                                              : w_sel_count + 1'b1;
    assign w_task_ext  = {{lrcs_pkg::OUT_TASK_W{1'b0}}, r_task_c};

    assign w_can_out  = ~r_out_valid | o_out.ready;
    assign w_finish   = (r_state == lrcs_pkg::ST_WRITE) & w_can_out;
    assign i_in.ready = (r_state == lrcs_pkg::ST_IDLE) | w_finish;
    assign w_accept   = i_in.valid & i_in.ready;

    always_comb begin
        n_state      = r_state;
        w_ctl.pick   = 1'b0;
        w_ctl.update = 1'b0;
        case (r_state)
            lrcs_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = lrcs_pkg::ST_PICK;
                end
            end
            lrcs_pkg::ST_PICK: begin
                w_ctl.pick = 1'b1;
                n_state    = lrcs_pkg::ST_WRITE;
            end
            lrcs_pkg::ST_WRITE: begin
                if (w_can_out) begin
                    w_ctl.update = r_found;
                    n_state      = w_accept ? lrcs_pkg::ST_PICK : lrcs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lrcs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lrcs_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_ctl.pick) begin
                r_found <= w_link[TASKS].hit;
            end
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mask <= i_in.runnable_mask;
        end
        if (w_ctl.pick) begin
            r_task_c  <= w_sel_task;
            r_count_c <= w_inc_count;
        end
        if (w_finish) begin
            r_out_found <= r_found;
            r_out_task  <= r_found ? w_task_ext[lrcs_pkg::OUT_TASK_W-1:0] : '0;
            r_out_count <= r_found ? r_count_c : '0;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.found        = r_out_found;
    assign o_out.chosen_task  = r_out_task;
    assign o_out.chosen_count = r_out_count;

    // at most one cell holds the select flag
    a_sel_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_sel))
        else $error("more than one cell selected");

    // the found flag agrees with the cell select flags during the update
    a_found_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lrcs_pkg::ST_WRITE) |-> (r_found == (|w_sel)))
        else $error("found flag disagrees with cell selection");

    // an accepted request always goes to the pick phase
    a_accept_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == lrcs_pkg::ST_PICK))
        else $error("accepted request not picked");

    // a finished decision is presented in the next cycle
    a_finish_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_finish |=> r_out_valid)
        else $error("decision lost");

    // a decision with nothing found reports zero task and count
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_found) |-> (r_out_task == '0 && r_out_count == '0))
        else $error("empty decision carries data");

endmodule

// File: test/lrcs_decision_checker.sv
// checker that predicts and compares scheduling decisions of the least-run-count scheduler
module lrcs_decision_checker #(
    parameter int TASKS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_req_valid,
    input  logic                              i_req_ready,
    input  logic [lrcs_pkg::MASK_W-1:0]       i_req_mask,
    input  logic                              i_dec_valid,
    input  logic                              i_dec_ready,
    input  logic                              i_dec_found,
    input  logic [lrcs_pkg::OUT_TASK_W-1:0]   i_dec_task,
    input  logic [lrcs_pkg::COUNT_W-1:0]      i_dec_count,
    output int                                o_fail_count,
    output int                                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                            found;
        logic [lrcs_pkg::OUT_TASK_W-1:0] task_id;
        logic [lrcs_pkg::COUNT_W-1:0]    count;
    } t_decision;

    // predicted queue: task number and run count per slot, ascending count
    int unsigned                  slot_task  [TASKS];
    logic [lrcs_pkg::COUNT_W-1:0] slot_count [TASKS];

    t_decision decision_q [$];

    function automatic void reset_schedule();
        for (int k = 0; k < TASKS; k++) begin
            slot_task[k]  = k;
            slot_count[k] = '0;
        end
    endfunction

    // pick first runnable slot, bump its count and slide it back past lower counts
    function automatic t_decision schedule_pick(input logic [lrcs_pkg::MASK_W-1:0] mask);
        t_decision                    d;
        int                           slot;
        int unsigned                  tmp_task;
        logic [lrcs_pkg::COUNT_W-1:0] tmp_count;
        d    = '0;
        slot = -1;
        for (int i = 0; i < TASKS; i++) begin
            if (slot < 0 && slot_task[i] < lrcs_pkg::MASK_W && mask[slot_task[i]])
                slot = i;
        end
        if (slot >= 0) begin
            if (slot_count[slot] != lrcs_pkg::COUNT_MAX)
                slot_count[slot] = slot_count[slot] + 1'b1;
            d.found   = 1'b1;
            d.task_id = lrcs_pkg::OUT_TASK_W'(slot_task[slot]);
            d.count   = slot_count[slot];
            while (slot + 1 < TASKS && slot_count[slot+1] < slot_count[slot]) begin
                tmp_task             = slot_task[slot];
                tmp_count            = slot_count[slot];
                slot_task[slot]      = slot_task[slot+1];
                slot_count[slot]     = slot_count[slot+1];
                slot_task[slot+1]    = tmp_task;
                slot_count[slot+1]   = tmp_count;
                slot++;
            end
        end
        return d;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: decision mismatch: %s", $time, msg);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_decision want;
        if (!i_rst_n) begin
            reset_schedule();
            decision_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_dec_valid && i_dec_ready) begin
                if (decision_q.size() == 0) begin
                    report_mismatch("decision with no request outstanding");
                end else begin
                    want = decision_q.pop_front();
                    if (i_dec_found !== want.found)
                        report_mismatch($sformatf("found: got %0h, expected %0h",
                                                  i_dec_found, want.found));
                    if (i_dec_task !== want.task_id)
                        report_mismatch($sformatf("chosen_task: got %0h, expected %0h",
                                                  i_dec_task, want.task_id));
                    if (i_dec_count !== want.count)
                        report_mismatch($sformatf("chosen_count: got %0h, expected %0h",
                                                  i_dec_count, want.count));
                end
            end
            if (i_req_valid && i_req_ready)
                decision_q.push_back(schedule_pick(i_req_mask));
        end
        o_pending = decision_q.size();
    end

endmodule

// File: test/least_run_count_scheduler_unit_tb.sv
// testbench top for the least-run-count scheduler: stimulus, handshake idling and verdict
module least_run_count_scheduler_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TASKS        = 16;
    localparam int RANDOM_ITEMS = 1150;

    logic clk;
    logic rst_n = 1'b0;

    logic                        src_valid = 1'b0;
    logic [lrcs_pkg::MASK_W-1:0] src_mask  = '0;
    logic                        sink_ready = 1'b0;
    logic                        no_idle    = 1'b0;
    int                          sink_stall = 0;
    int                          fail_count;
    int                          pending;

    lrcs_in_if  req_ch ();
    lrcs_out_if dec_ch ();

    assign req_ch.valid         = src_valid;
    assign req_ch.runnable_mask = src_mask;
    assign dec_ch.ready         = sink_ready;

    least_run_count_scheduler_unit #(
        .TASKS (TASKS)
    ) u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (req_ch),
        .o_out   (dec_ch)
    );

    lrcs_decision_checker #(
        .TASKS (TASKS)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (req_ch.valid),
        .i_req_ready  (req_ch.ready),
        .i_req_mask   (req_ch.runnable_mask),
        .i_dec_valid  (dec_ch.valid),
        .i_dec_ready  (dec_ch.ready),
        .i_dec_found  (dec_ch.found),
        .i_dec_task   (dec_ch.chosen_task),
        .i_dec_count  (dec_ch.chosen_count),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #10_000_000;
        $display("least_run_count_scheduler_unit_tb failed");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // sparse masks dominate so that ties and reordering happen often
    function automatic logic [lrcs_pkg::MASK_W-1:0] random_mask();
        int                          r;
        logic [lrcs_pkg::MASK_W-1:0] m;
        r = $urandom_range(0, 99);
        m = '0;
        if (r < 10) begin
            m = '0;
        end else if (r < 20) begin
            m = '1;
        end else if (r < 55) begin
            m[$urandom_range(0, lrcs_pkg::MASK_W-1)] = 1'b1;
        end else if (r < 75) begin
            repeat ($urandom_range(2, 3)) m[$urandom_range(0, lrcs_pkg::MASK_W-1)] = 1'b1;
        end else begin
            m = lrcs_pkg::MASK_W'($urandom());
        end
        return m;
    endfunction

    always @(posedge clk) begin
        if (!rst_n) begin
            sink_ready <= 1'b0;
            sink_stall <= 0;
        end else if (sink_stall > 0) begin
            sink_ready <= 1'b0;
            sink_stall <= sink_stall - 1;
        end else if (!no_idle && $urandom_range(0, 99) < 20) begin
            sink_ready <= 1'b0;
            sink_stall <= idle_len();
        end else begin
            sink_ready <= 1'b1;
        end
    end

    task automatic send_request(input logic [lrcs_pkg::MASK_W-1:0] mask);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            src_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        src_valid <= 1'b1;
        src_mask  <= mask;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
    endtask

    initial begin : stimulus
        logic [lrcs_pkg::MASK_W-1:0] directed [$];
        directed = '{16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555, 16'h8001, 16'h8000};
        for (int b = 0; b < lrcs_pkg::MASK_W; b++)
            directed.push_back(lrcs_pkg::MASK_W'(1) << b);
        directed.push_back(16'h0000);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_request(directed[i]);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // every third stretch of 150 items runs with no idling on either side
            no_idle = ((n / 150) % 3) == 2;
            send_request(random_mask());
        end
        no_idle = 1'b0;
        src_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        if (fail_count == 0)
            $display("least_run_count_scheduler_unit_tb passed");
        else
            $display("least_run_count_scheduler_unit_tb failed");
        $finish;
    end

endmodule

// File: sim.f
src/lrcs_pkg.sv
src/lrcs_if.sv
src/lrcs_cell.sv
src/least_run_count_scheduler_unit.sv
test/lrcs_decision_checker.sv
test/least_run_count_scheduler_unit_tb.sv
